// ===== rtl/prg_pkg.sv =====
// shared types and constants of the pinhole camera ray generator
package prg_pkg;

    localparam int SLOT_W = 21;
    localparam int PACK_W = 63;
    localparam int STEP_W = 32;
    localparam int DIM_W = 13;
    localparam int OFS_W = 40;
    localparam int DIR_W = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [OFS_W-1:0] OFS_SAT = 40'h7F_FFFF_FFFF;

    localparam logic [2:0] CFG_FORWARD = 3'd0;
    localparam logic [2:0] CFG_RIGHT = 3'd1;
    localparam logic [2:0] CFG_UP = 3'd2;
    localparam logic [2:0] CFG_EYE = 3'd3;
    localparam logic [2:0] CFG_STEP_X = 3'd4;
    localparam logic [2:0] CFG_STEP_Y = 3'd5;
    localparam logic [2:0] CFG_WIDTH = 3'd6;
    localparam logic [2:0] CFG_HEIGHT = 3'd7;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [15:0] jitter_x;
        logic [15:0] jitter_y;
    } t_in;

    typedef struct packed {
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
        logic [PACK_W-1:0]       ray_origin;
        logic                    degenerate;
    } t_out;

    typedef struct packed {
        logic [PACK_W-1:0] forward_dir;
        logic [PACK_W-1:0] right_dir;
        logic [PACK_W-1:0] up_dir;
        logic [PACK_W-1:0] eye_position;
        logic [STEP_W-1:0] step_x;
        logic [STEP_W-1:0] step_y;
        logic [DIM_W-1:0]  image_width;
        logic [DIM_W-1:0]  image_height;
    } t_cfg;

    // scaled image plane offsets handed from front to back
    typedef struct packed {
        logic signed [OFS_W-1:0] alpha;
        logic signed [OFS_W-1:0] beta;
    } t_ofs;

endpackage

// ===== rtl/prg_front.sv =====
// front end: pixel offsets from center and their scaling by the pixel steps
module prg_front
    import prg_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int JITTER_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_in,
    input  t_cfg i_cfg,
    output logic o_push,
    output t_ofs o_ofs,
    input  logic i_full
);

    localparam int CU = (COORD_BITS < 12) ? COORD_BITS : 12;
    localparam int JU = (JITTER_BITS < 16) ? JITTER_BITS : 16;
    localparam int DW = ((COORD_BITS > 12) ? COORD_BITS : 12) + JITTER_BITS;
    localparam int PW = STEP_W + DW;
    localparam logic [11:0] CMASK = 12'((64'd1 << CU) - 64'd1);
    localparam logic [15:0] JMASK = 16'((64'd1 << JU) - 64'd1);

    logic          en;
    logic [DW-1:0] px, py, cx, cy;
    logic          r_f1_v, r_f2_v;
    logic          r_neg_x, r_neg_y, r_neg2_x, r_neg2_y;
    logic [DW-1:0] r_mag_x, r_mag_y;
    logic [PW-1:0] r_prod_x, r_prod_y;
    logic [PW-1:0] sh_x, sh_y;
    logic [OFS_W-1:0] p_x, p_y;

    assign en = !(r_f2_v && i_full);
    assign o_stall = !en;
    assign o_push = r_f2_v && !i_full;

    always_comb begin
        px = (DW'(i_in.pixel_x & CMASK) << JITTER_BITS) + DW'(i_in.jitter_x & JMASK);
        py = (DW'(i_in.pixel_y & CMASK) << JITTER_BITS) + DW'(i_in.jitter_y & JMASK);
        cx = DW'(i_cfg.image_width[DIM_W-1:1]) << JITTER_BITS;
        cy = DW'(i_cfg.image_height[DIM_W-1:1]) << JITTER_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
        end else if (en) begin
            r_f1_v <= i_valid;
            r_f2_v <= r_f1_v;
        end
        if (en) begin
            r_neg_x <= px < cx;
            r_mag_x <= (px < cx) ? cx - px : px - cx;
            r_neg_y <= cy < py;
            r_mag_y <= (cy < py) ? py - cy : cy - py;
            r_neg2_x <= r_neg_x;
            r_neg2_y <= r_neg_y;
            r_prod_x <= PW'(i_cfg.step_x) * PW'(r_mag_x);
            r_prod_y <= PW'(i_cfg.step_y) * PW'(r_mag_y);
        end
    end

    // drop the jitter fraction and clamp to the offset range
    always_comb begin
        sh_x = r_prod_x >> JITTER_BITS;
        sh_y = r_prod_y >> JITTER_BITS;
        p_x = (sh_x > PW'(OFS_SAT)) ? OFS_SAT : OFS_W'(sh_x);
        p_y = (sh_y > PW'(OFS_SAT)) ? OFS_SAT : OFS_W'(sh_y);
        o_ofs.alpha = r_neg2_x ? -$signed(p_x) : $signed(p_x);
        o_ofs.beta = r_neg2_y ? -$signed(p_y) : $signed(p_y);
    end

endmodule

// ===== rtl/prg_queue.sv =====
// short fifo between front and back
module prg_queue
    import prg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_ofs i_data,
    output logic o_full,
    input  logic i_pop,
    output t_ofs o_data,
    output logic o_empty
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_ofs          r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full = r_cnt == (AW+1)'(QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop) r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule

// ===== rtl/prg_back.sv =====
// back end: direction sum, block normalize, square root, divide and output register
module prg_back
    import prg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  t_ofs i_ofs,
    input  logic i_empty,
    output logic o_pop,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_out
);

    localparam int NSQ = 31;
    localparam int NDV = 31;
    localparam int NV = 7 + NSQ + NDV;

    logic en;
    logic [NV-1:0] r_vld;
    logic r_out_valid;

    // s1 products, s2 magnitudes, s3 max, s4 length, s5 shift, s6 squares, s7 sum
    logic signed [60:0] r_pr [3], r_pu [3];
    logic signed [20:0] r_f1 [3];
    logic [60:0] r_mag2 [3], r_mag3 [3], r_mag4 [3];
    logic [2:0] r_neg2, r_neg3, r_neg4, r_neg5, r_neg6, r_neg7;
    logic [60:0] r_m3;
    logic [5:0] r_len4;
    logic r_deg4, r_deg5, r_deg6, r_deg7;
    logic [29:0] r_u5 [3], r_u6 [3], r_u7 [3];
    logic [59:0] r_sq6 [3];
    logic [61:0] r_s7;

    logic signed [61:0] vsum [3];
    logic [60:0] mmax;
    logic [5:0] len;

    // square root pipeline, one result bit per stage
    logic [61:0] r_qs [NSQ];
    logic [34:0] r_qrem [NSQ];
    logic [30:0] r_qroot [NSQ];
    logic [29:0] r_qu [NSQ][3];
    logic [2:0] r_qneg [NSQ];
    logic r_qdeg [NSQ];
    logic [61:0] c_qs [NSQ];
    logic [34:0] c_qrem [NSQ], n_qrem [NSQ];
    logic [30:0] c_qroot [NSQ], n_qroot [NSQ];
    logic [34:0] qt, qtrial;

    // divider pipeline, three lanes sharing the root
    logic [30:0] r_dr [NDV];
    logic [30:0] r_drem [NDV][3], r_dq [NDV][3];
    logic [2:0] r_dneg [NDV];
    logic r_ddeg [NDV];
    logic [30:0] c_dr [NDV];
    logic [30:0] c_drem [NDV][3], c_dq [NDV][3], n_drem [NDV][3], n_dq [NDV][3];
    logic [2:0] c_dlsb [NDV], c_dneg [NDV];
    logic c_ddeg [NDV];
    logic [31:0] dt;

    assign en = !r_out_valid || !i_stall;
    assign o_pop = en && !i_empty;
    assign o_valid = r_out_valid;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vsum[i] = (62'(r_f1[i]) <<< 24) + 62'(r_pr[i]) + 62'(r_pu[i]);
        end
        mmax = (r_mag2[0] > r_mag2[1]) ? r_mag2[0] : r_mag2[1];
        mmax = (mmax > r_mag2[2]) ? mmax : r_mag2[2];
        len = '0;
        for (int b = 0; b < 61; b++) begin
            if (r_m3[b]) len = 6'(b + 1);
        end
    end

    // stage inputs of the root and divide chains
    always_comb begin
        c_qs[0] = r_s7;
        c_qrem[0] = '0;
        c_qroot[0] = '0;
        for (int k = 1; k < NSQ; k++) begin
            c_qs[k] = r_qs[k-1];
            c_qrem[k] = r_qrem[k-1];
            c_qroot[k] = r_qroot[k-1];
        end
        for (int k = 0; k < NSQ; k++) begin
            qt = {c_qrem[k][32:0], c_qs[k][61-2*k -: 2]};
            qtrial = {2'b00, c_qroot[k], 2'b01};
            if (qt >= qtrial) begin
                n_qrem[k] = qt - qtrial;
                n_qroot[k] = {c_qroot[k][29:0], 1'b1};
            end else begin
                n_qrem[k] = qt;
                n_qroot[k] = {c_qroot[k][29:0], 1'b0};
            end
        end

        c_dr[0] = r_qroot[NSQ-1];
        c_dneg[0] = r_qneg[NSQ-1];
        c_ddeg[0] = r_qdeg[NSQ-1];
        for (int i = 0; i < 3; i++) begin
            c_drem[0][i] = 31'(r_qu[NSQ-1][i] >> 1);
            c_dq[0][i] = '0;
            c_dlsb[0][i] = r_qu[NSQ-1][i][0];
        end
        for (int j = 1; j < NDV; j++) begin
            c_dr[j] = r_dr[j-1];
            c_dneg[j] = r_dneg[j-1];
            c_ddeg[j] = r_ddeg[j-1];
            c_dlsb[j] = '0;
            for (int i = 0; i < 3; i++) begin
                c_drem[j][i] = r_drem[j-1][i];
                c_dq[j][i] = r_dq[j-1][i];
            end
        end
        for (int j = 0; j < NDV; j++) begin
            for (int i = 0; i < 3; i++) begin
                dt = {c_drem[j][i], c_dlsb[j][i]};
                if (dt >= {1'b0, c_dr[j]}) begin
                    n_drem[j][i] = 31'(dt - {1'b0, c_dr[j]});
                    n_dq[j][i] = {c_dq[j][i][29:0], 1'b1};
                end else begin
                    n_drem[j][i] = 31'(dt);
                    n_dq[j][i] = {c_dq[j][i][29:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld <= {r_vld[NV-2:0], !i_empty};
            r_out_valid <= r_vld[NV-1];
        end
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_f1[i] <= $signed(i_cfg.forward_dir[SLOT_W*i +: SLOT_W]);
                r_pr[i] <= i_ofs.alpha * $signed(i_cfg.right_dir[SLOT_W*i +: SLOT_W]);
                r_pu[i] <= i_ofs.beta * $signed(i_cfg.up_dir[SLOT_W*i +: SLOT_W]);
                r_neg2[i] <= vsum[i][61];
                r_mag2[i] <= vsum[i][61] ? 61'(-vsum[i]) : 61'(vsum[i]);
                r_mag3[i] <= r_mag2[i];
                r_mag4[i] <= r_mag3[i];
                if (r_len4 > 6'd30) r_u5[i] <= 30'(r_mag4[i] >> (r_len4 - 6'd30));
                else r_u5[i] <= 30'(r_mag4[i] << (6'd30 - r_len4));
                r_u6[i] <= r_u5[i];
                r_sq6[i] <= 60'(r_u5[i]) * 60'(r_u5[i]);
                r_u7[i] <= r_u6[i];
            end
            r_neg3 <= r_neg2;
            r_m3 <= mmax;
            r_neg4 <= r_neg3;
            r_len4 <= len;
            r_deg4 <= r_m3 == '0;
            r_neg5 <= r_neg4;
            r_deg5 <= r_deg4;
            r_neg6 <= r_neg5;
            r_deg6 <= r_deg5;
            r_s7 <= 62'(r_sq6[0]) + 62'(r_sq6[1]) + 62'(r_sq6[2]);
            r_neg7 <= r_neg6;
            r_deg7 <= r_deg6;

            for (int k = 0; k < NSQ; k++) begin
                r_qs[k] <= c_qs[k];
                r_qrem[k] <= n_qrem[k];
                r_qroot[k] <= n_qroot[k];
            end
            r_qu[0] <= r_u7;
            r_qneg[0] <= r_neg7;
            r_qdeg[0] <= r_deg7;
            for (int k = 1; k < NSQ; k++) begin
                r_qu[k] <= r_qu[k-1];
                r_qneg[k] <= r_qneg[k-1];
                r_qdeg[k] <= r_qdeg[k-1];
            end

            for (int j = 0; j < NDV; j++) begin
                r_dr[j] <= c_dr[j];
                r_dneg[j] <= c_dneg[j];
                r_ddeg[j] <= c_ddeg[j];
                for (int i = 0; i < 3; i++) begin
                    r_drem[j][i] <= n_drem[j][i];
                    r_dq[j][i] <= n_dq[j][i];
                end
            end

            o_out.ray_origin <= i_cfg.eye_position;
            o_out.degenerate <= r_ddeg[NDV-1];
            if (r_ddeg[NDV-1]) begin
                o_out.dir_x <= '0;
                o_out.dir_y <= '0;
                o_out.dir_z <= '0;
            end else begin
                o_out.dir_x <= r_dneg[NDV-1][0] ? -$signed({1'b0, r_dq[NDV-1][0]})
                                                 : $signed({1'b0, r_dq[NDV-1][0]});
                o_out.dir_y <= r_dneg[NDV-1][1] ? -$signed({1'b0, r_dq[NDV-1][1]})
                                                 : $signed({1'b0, r_dq[NDV-1][1]});
                o_out.dir_z <= r_dneg[NDV-1][2] ? -$signed({1'b0, r_dq[NDV-1][2]})
                                                 : $signed({1'b0, r_dq[NDV-1][2]});
            end
        end
    end

endmodule

// ===== rtl/pinhole_camera_ray_generator.sv =====
// top level of the pinhole camera primary ray generator
// takes one pixel transaction per cycle and returns one ray transaction per cycle
// while nothing stalls; a pixel passes two front stages, the queue, 69 back stages
// and the output register. most of the back stages belong to the bit-per-stage
// square root (31 stages) and the three-lane restoring divider (31 stages). the
// front computes the centered sub-pixel offsets and scales them by the pixel
// steps; a four-entry queue lets it keep taking pixels while the back end waits
// on a stalled output. the back end forms forward + alpha*right + beta*up,
// block-normalizes it to 30 bits, takes the length and divides each component
// by it to give a q1.30 unit direction. a zero vector gives a zero direction
// with degenerate set. the eye position is copied to each ray; configuration
// is to be written only while no transaction is in flight, which the block
// itself does not enforce.
module pinhole_camera_ray_generator
    import prg_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int JITTER_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_addr,
    input  logic [PACK_W-1:0] i_cfg_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_in               i_in,
    output logic              o_valid,
    input  logic              i_stall,
    output t_out              o_out
);

    t_cfg r_cfg;
    logic q_push, q_full, q_pop, q_empty;
    t_ofs f_ofs, q_ofs;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.forward_dir <= '0;
            r_cfg.right_dir <= '0;
            r_cfg.up_dir <= '0;
            r_cfg.eye_position <= '0;
            r_cfg.step_x <= '0;
            r_cfg.step_y <= '0;
            r_cfg.image_width <= DIM_W'(512);
            r_cfg.image_height <= DIM_W'(512);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_FORWARD: r_cfg.forward_dir <= i_cfg_data;
                CFG_RIGHT:   r_cfg.right_dir <= i_cfg_data;
                CFG_UP:      r_cfg.up_dir <= i_cfg_data;
                CFG_EYE:     r_cfg.eye_position <= i_cfg_data;
                CFG_STEP_X:  r_cfg.step_x <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_Y:  r_cfg.step_y <= i_cfg_data[STEP_W-1:0];
                CFG_WIDTH:   r_cfg.image_width <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT:  r_cfg.image_height <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // offsets from the image center, scaled by the pixel steps
    prg_front #(
        .COORD_BITS (COORD_BITS),
        .JITTER_BITS(JITTER_BITS)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_in   (i_in),
        .i_cfg  (r_cfg),
        .o_push (q_push),
        .o_ofs  (f_ofs),
        .i_full (q_full)
    );

    // decouples the front from output stalls
    prg_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (f_ofs),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_data (q_ofs),
        .o_empty(q_empty)
    );

    // direction build and normalization
    prg_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (r_cfg),
        .i_ofs  (q_ofs),
        .i_empty(q_empty),
        .o_pop  (q_pop),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_out  (o_out)
    );

endmodule

// ===== tb/pinhole_camera_ray_generator_tb.sv =====
// testbench of the pinhole camera ray generator: directed and random pixels, self-checking
module pinhole_camera_ray_generator_tb
    import prg_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // drain waits this long after the last ray, longer than the pixel-to-ray path
    localparam int LATENCY_WAIT = 120;
    // run limit with plenty of margin over a correct run
    localparam longint CYCLE_LIMIT = 400000;
    localparam int RANDOM_PIXELS = 350;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [2:0]        i_cfg_addr;
    logic [PACK_W-1:0] i_cfg_data;
    logic              i_valid;
    logic              o_stall;
    t_in               i_in;
    logic              o_valid;
    logic              i_stall;
    t_out              o_out;

    pinhole_camera_ray_generator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out      (o_out)
    );

    // shadow copy of the camera registers
    logic [PACK_W-1:0] cam_forward, cam_right, cam_up, cam_eye;
    logic [STEP_W-1:0] cam_step_x, cam_step_y;
    logic [DIM_W-1:0]  cam_width, cam_height;

    t_out   expected_rays[$];
    int     error_count;
    int     rays_checked;
    int     degenerate_seen;
    int     pixels_sent;
    longint cycle_count;
    int     sender_idle_pct;
    int     receiver_stall_pct;

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver back-pressure, changed on the falling edge
    always @(negedge i_clk) begin
        i_stall = ($urandom_range(0, 99) < receiver_stall_pct);
    end

    // signed q1.19 slot of a packed vector
    function automatic longint slot_value(logic [PACK_W-1:0] packed_vec, int idx);
        logic signed [SLOT_W-1:0] s;
        s = packed_vec[SLOT_W*idx +: SLOT_W];
        return longint'(s);
    endfunction

    // step times a q.16 offset magnitude, saturated to the q15.24 range
    function automatic longint scale_offset(longint unsigned step, bit neg,
                                            longint unsigned mag);
        longint unsigned p;
        p = step * (mag >> 16) + ((step * (mag & 64'hFFFF)) >> 16);
        if (p > 64'h7F_FFFF_FFFF)
            p = 64'h7F_FFFF_FFFF;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    // floor of the square root, one result bit per round
    function automatic longint unsigned root_floor(longint unsigned s);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > s)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (s >= res + bitv) begin
                s = s - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // expected ray of one pixel under the current camera registers
    function automatic t_out trace_ray(t_in pix);
        t_out            ray;
        longint unsigned px, py, cx, cy, m, s, r, q;
        longint unsigned mag[3];
        longint          v[3];
        longint          alpha, beta;
        int              len;
        px = (longint'(pix.pixel_x) << 16) + pix.jitter_x;
        py = (longint'(pix.pixel_y) << 16) + pix.jitter_y;
        cx = longint'(cam_width >> 1) << 16;
        cy = longint'(cam_height >> 1) << 16;
        alpha = (px >= cx) ? scale_offset(64'(cam_step_x), 1'b0, px - cx)
                           : scale_offset(64'(cam_step_x), 1'b1, cx - px);
        beta  = (cy >= py) ? scale_offset(64'(cam_step_y), 1'b0, cy - py)
                           : scale_offset(64'(cam_step_y), 1'b1, py - cy);
        m = 0;
        for (int i = 0; i < 3; i++) begin
            v[i] = slot_value(cam_forward, i) * (longint'(1) << 24)
                 + alpha * slot_value(cam_right, i)
                 + beta * slot_value(cam_up, i);
            mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            if (mag[i] > m)
                m = mag[i];
        end
        ray = '0;
        ray.ray_origin = cam_eye;
        if (m == 0) begin
            ray.degenerate = 1'b1;
            return ray;
        end
        // block normalize so the largest magnitude sits in [2^29, 2^30)
        len = 0;
        while (len < 64 && (m >> len) != 0)
            len++;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            if (len > 30)
                mag[i] = mag[i] >> (len - 30);
            else
                mag[i] = mag[i] << (30 - len);
            s = s + mag[i] * mag[i];
        end
        r = root_floor(s);
        if (r == 0)
            r = 1;
        for (int i = 0; i < 3; i++) begin
            q = (mag[i] << 30) / r;
            if (v[i] < 0) begin
                if (q > 64'h8000_0000)
                    q = 64'h8000_0000;
                q = -q;
            end else if (q > 64'h7FFF_FFFF) begin
                q = 64'h7FFF_FFFF;
            end
            case (i)
                0: ray.dir_x = q[31:0];
                1: ray.dir_y = q[31:0];
                default: ray.dir_z = q[31:0];
            endcase
        end
        return ray;
    endfunction

    // ray checker: every accepted ray against the oldest expectation
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_rays.size() == 0) begin
                $error("ray transaction with no pixel outstanding");
                error_count++;
            end else begin
                want = expected_rays.pop_front();
                rays_checked++;
                if (want.degenerate)
                    degenerate_seen++;
                if (o_out.dir_x !== want.dir_x) begin
                    $error("dir_x expected %0d actual %0d", want.dir_x, o_out.dir_x);
                    error_count++;
                end
                if (o_out.dir_y !== want.dir_y) begin
                    $error("dir_y expected %0d actual %0d", want.dir_y, o_out.dir_y);
                    error_count++;
                end
                if (o_out.dir_z !== want.dir_z) begin
                    $error("dir_z expected %0d actual %0d", want.dir_z, o_out.dir_z);
                    error_count++;
                end
                if (o_out.ray_origin !== want.ray_origin) begin
                    $error("ray_origin expected %h actual %h",
                           want.ray_origin, o_out.ray_origin);
                    error_count++;
                end
                if (o_out.degenerate !== want.degenerate) begin
                    $error("degenerate expected %b actual %b",
                           want.degenerate, o_out.degenerate);
                    error_count++;
                end
            end
        end
    end

    // one register write; only called while nothing is in flight
    task automatic write_reg(logic [2:0] addr, logic [PACK_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_addr = addr;
        i_cfg_data = data;
        case (addr)
            CFG_FORWARD: cam_forward = data;
            CFG_RIGHT:   cam_right = data;
            CFG_UP:      cam_up = data;
            CFG_EYE:     cam_eye = data;
            CFG_STEP_X:  cam_step_x = data[STEP_W-1:0];
            CFG_STEP_Y:  cam_step_y = data[STEP_W-1:0];
            CFG_WIDTH:   cam_width = data[DIM_W-1:0];
            default:     cam_height = data[DIM_W-1:0];
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // send one pixel transaction, with random idle cycles ahead of it
    task automatic send_pixel(t_in pix);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_in = pix;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        expected_rays.push_back(trace_ray(pix));
        pixels_sent++;
    endtask

    // stop sending and wait for every outstanding ray, then let the pipe settle
    task automatic drain;
        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_rays.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY_WAIT) @(posedge i_clk);
    endtask

    function automatic t_in random_pixel();
        t_in pix;
        pix.pixel_x = 12'($urandom);
        pix.pixel_y = 12'($urandom);
        pix.jitter_x = 16'($urandom);
        pix.jitter_y = 16'($urandom);
        // keep many pixels inside the configured image
        if ($urandom_range(0, 3) != 0) begin
            pix.pixel_x = 12'($urandom_range(0, (cam_width > 0) ? cam_width - 1 : 0));
            pix.pixel_y = 12'($urandom_range(0, (cam_height > 0) ? cam_height - 1 : 0));
        end
        return pix;
    endfunction

    function automatic logic [PACK_W-1:0] pack_vec(int x, int y, int z);
        logic [SLOT_W-1:0] sx, sy, sz;
        sx = SLOT_W'(x);
        sy = SLOT_W'(y);
        sz = SLOT_W'(z);
        return {sz, sy, sx};
    endfunction

    function automatic logic [PACK_W-1:0] random_word();
        return PACK_W'({$urandom, $urandom});
    endfunction

    // a basis vector with each slot in [-1, 1], or an arbitrary one
    function automatic logic [PACK_W-1:0] random_axis();
        if ($urandom_range(0, 3) == 0)
            return random_word();
        return pack_vec($urandom_range(0, 2 ** 20) - 2 ** 19,
                        $urandom_range(0, 2 ** 20) - 2 ** 19,
                        $urandom_range(0, 2 ** 20) - 2 ** 19);
    endfunction

    task automatic random_camera();
        write_reg(CFG_FORWARD, random_axis());
        write_reg(CFG_RIGHT, random_axis());
        write_reg(CFG_UP, random_axis());
        write_reg(CFG_EYE, random_word());
        write_reg(CFG_STEP_X, PACK_W'($urandom >> $urandom_range(0, 31)));
        write_reg(CFG_STEP_Y, PACK_W'($urandom >> $urandom_range(0, 31)));
        write_reg(CFG_WIDTH, PACK_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                                                  : $urandom_range(1, 4096)));
        write_reg(CFG_HEIGHT, PACK_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                                                   : $urandom_range(1, 4096)));
    endtask

    // registers at reset: zero basis, every ray degenerate
    task automatic test_reset_state();
        t_in pix;
        for (int i = 0; i < 4; i++) begin
            pix = random_pixel();
            send_pixel(pix);
        end
        drain();
    endtask

    // extremes of pixel and jitter fields, center, saturated offsets, odd and zero size
    task automatic test_directed();
        t_in pix;
        write_reg(CFG_FORWARD, pack_vec(0, 0, -(2 ** 19)));
        write_reg(CFG_RIGHT, pack_vec(2 ** 19, 0, 0));
        write_reg(CFG_UP, pack_vec(0, 2 ** 19, 0));
        write_reg(CFG_EYE, 63'h7FFF_FFFF_FFFF_FFFF);
        write_reg(CFG_STEP_X, PACK_W'(32'h0001_0000));
        write_reg(CFG_STEP_Y, PACK_W'(32'h0001_0000));
        write_reg(CFG_WIDTH, PACK_W'(13'd640));
        write_reg(CFG_HEIGHT, PACK_W'(13'd480));
        send_pixel('{pixel_x: 12'd320, pixel_y: 12'd240, jitter_x: 16'd0, jitter_y: 16'd0});
        send_pixel('{pixel_x: 12'd0, pixel_y: 12'd0, jitter_x: 16'd0, jitter_y: 16'd0});
        send_pixel('{pixel_x: 12'hFFF, pixel_y: 12'hFFF, jitter_x: 16'hFFFF,
                     jitter_y: 16'hFFFF});
        send_pixel('{pixel_x: 12'd319, pixel_y: 12'd239, jitter_x: 16'hFFFF,
                     jitter_y: 16'hFFFF});
        drain();
        // full-scale steps saturate alpha and beta
        write_reg(CFG_STEP_X, PACK_W'(32'hFFFF_FFFF));
        write_reg(CFG_STEP_Y, PACK_W'(32'hFFFF_FFFF));
        send_pixel('{pixel_x: 12'hFFF, pixel_y: 12'd0, jitter_x: 16'hFFFF, jitter_y: 16'd0});
        send_pixel('{pixel_x: 12'd0, pixel_y: 12'hFFF, jitter_x: 16'd0, jitter_y: 16'hFFFF});
        drain();
        // zero and odd sizes, widest register value
        write_reg(CFG_WIDTH, PACK_W'(13'd0));
        write_reg(CFG_HEIGHT, PACK_W'(13'd1));
        write_reg(CFG_STEP_X, PACK_W'(32'h0000_0001));
        send_pixel('{pixel_x: 12'd0, pixel_y: 12'd0, jitter_x: 16'd0, jitter_y: 16'd0});
        send_pixel('{pixel_x: 12'd1, pixel_y: 12'd0, jitter_x: 16'd1, jitter_y: 16'd1});
        drain();
        write_reg(CFG_WIDTH, PACK_W'(13'h1FFF));
        write_reg(CFG_HEIGHT, PACK_W'(13'h1FFF));
        send_pixel('{pixel_x: 12'hFFF, pixel_y: 12'hFFF, jitter_x: 16'h8000, jitter_y: 16'h8000});
        drain();
        // zero forward at the center gives a zero vector
        write_reg(CFG_FORWARD, '0);
        write_reg(CFG_WIDTH, PACK_W'(13'd8));
        write_reg(CFG_HEIGHT, PACK_W'(13'd8));
        send_pixel('{pixel_x: 12'd4, pixel_y: 12'd4, jitter_x: 16'd0, jitter_y: 16'd0});
        drain();
        // non-unit basis with forward and up slots at their extremes and all-ones right slots
        write_reg(CFG_FORWARD, pack_vec(-(2 ** 20), 2 ** 20 - 1, -(2 ** 20)));
        write_reg(CFG_RIGHT, 63'h7FFF_FFFF_FFFF_FFFF);
        write_reg(CFG_UP, pack_vec(-(2 ** 20), -(2 ** 20), -(2 ** 20)));
        write_reg(CFG_EYE, '0);
        for (int i = 0; i < 6; i++) begin
            pix = random_pixel();
            send_pixel(pix);
        end
        drain();
    endtask

    // random cameras and pixels under one idling pattern
    task automatic test_random_phase(int idle_pct, int stall_pct);
        t_in pix;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int c = 0; c < 3; c++) begin
            random_camera();
            for (int i = 0; i < RANDOM_PIXELS / 3; i++) begin
                pix = random_pixel();
                send_pixel(pix);
                // sender holds off until the pipe is empty once per camera
                if (i == RANDOM_PIXELS / 6) begin
                    drain();
                end
            end
            drain();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = CFG_FORWARD;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_in = '0;
        i_stall = 1'b0;
        error_count = 0;
        rays_checked = 0;
        degenerate_seen = 0;
        pixels_sent = 0;
        cycle_count = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        cam_forward = '0;
        cam_right = '0;
        cam_up = '0;
        cam_eye = '0;
        cam_step_x = '0;
        cam_step_y = '0;
        cam_width = 13'd512;
        cam_height = 13'd512;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_directed();
        test_random_phase(0, 0);
        test_random_phase(56, 0);
        test_random_phase(0, 56);
        test_random_phase(23, 23);

        $display("sent %0d pixels, checked %0d rays (%0d degenerate)",
                 pixels_sent, rays_checked, degenerate_seen);
        $display("covered reset state, field extremes, saturation, odd/zero sizes, idling");
        if (error_count == 0 && expected_rays.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
